/* hdl/a85_pkg.sv */
// Shared constants, types and command/status structs for the ascii85 group encoder.
package a85_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned CharW       = 7;
  localparam int unsigned WordW       = 32;
  localparam int unsigned HeldW       = 24;
  localparam int unsigned RecipShift  = 38;
  localparam int unsigned QuotW       = 2 * WordW - RecipShift;
  localparam int unsigned NumDigits   = 5;
  localparam int unsigned IdxW        = 3;

  localparam logic [CharW-1:0] CHAR_Y       = 7'd121;
  localparam logic [CharW-1:0] CHAR_Z       = 7'd122;
  localparam logic [CharW-1:0] DIGIT_OFFSET = 7'd33;
  localparam logic [ByteW-1:0] BASE         = 8'd85;
  localparam logic [WordW-1:0] SPACE_WORD   = 32'h2020_2020;
  localparam logic [WordW-1:0] RECIP        = 32'd3233857728;

  localparam logic [IdxW-1:0]  TOP_IDX      = 3'd4;
  localparam logic [1:0]       LAST_ITER    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic in_fire;
    logic mul_en;
    logic fix_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic shortcut;
    logic start_div;
    logic fix_done;
    logic idx_zero;
    logic out_free;
  } status_t;

endpackage

/* hdl/ascii85_group_encoder.sv */
// Top level of the ascii85 group encoder: byte stream in, encoded characters out.
// A byte that does not close a group is taken in ST_IDLE; a digit group passes through
// ST_MUL and ST_FIX before ST_EMIT loads its first character, a shortcut goes to ST_EMIT.
// A digit group holds the input through four passes of the shared reciprocal multiplier
// and through the one-character output register, output stalls included.
// Reset (rst, synchronous) empties the open group and drops any pending output.
module ascii85_group_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tuser,   // group_last
  output logic       m_tlast    // message_last
);
  import a85_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [CharW-1:0] out_char;

  a85_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  a85_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (s_tdata),
    .last_byte    (s_tlast),
    .out_ready    (m_tready),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_char     (out_char),
    .group_last   (m_tuser),
    .message_last (m_tlast)
  );

  assign s_tready = cmd.in_ready;
  assign m_tdata  = {1'b0, out_char};

`ifndef SYNTHESIS
  a_mlast_ends_group: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("message end not on a group end");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] >= DIGIT_OFFSET) && (m_tdata[6:0] <= CHAR_Z))
    else $error("output character out of range");

  a_no_load_while_ready: assert property (@(posedge clk) disable iff (rst)
    !(cmd.in_ready && (cmd.out_load || cmd.fix_en || cmd.mul_en)))
    else $error("input taken while a group is in work");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded character not presented");
`endif

endmodule

/* hdl/a85_ctrl.sv */
// Controller state machine: accept, divide iterations, character output.
module a85_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  a85_pkg::status_t  status,
  output a85_pkg::cmd_t     cmd
);
  import a85_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.in_fire  = s_tvalid;
        if (s_tvalid) begin
          if (status.shortcut) begin
            state_next = ST_EMIT;
          end else if (status.start_div) begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix_en = 1'b1;
        state_next = status.fix_done ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.idx_zero) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/a85_dp.sv */
// Datapath: group packing, base-85 digit extraction and output register.
module a85_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [a85_pkg::ByteW-1:0]     data_byte,
  input  logic                          last_byte,
  input  logic                          out_ready,
  input  a85_pkg::cmd_t                 cmd,
  output a85_pkg::status_t              status,
  output logic                          out_valid,
  output logic [a85_pkg::CharW-1:0]     out_char,
  output logic                          group_last,
  output logic                          message_last
);
  import a85_pkg::*;

  logic [HeldW-1:0]  group_word;
  logic [1:0]        byte_count;
  logic [WordW-1:0]  value;
  logic [QuotW-1:0]  quot_est;
  logic [1:0]        iter;
  logic [IdxW-1:0]   idx;
  logic              mlast;
  logic [CharW-1:0]  digits [NumDigits];

  logic              is_full;
  logic [WordW-1:0]  full_word;
  logic [HeldW-1:0]  word_next;
  logic [1:0]        count_next;
  logic [WordW-1:0]  padded;
  logic              is_zero;
  logic              is_space;
  logic [2*WordW-1:0] product;
  logic [WordW-1:0]  base_mult;
  logic [WordW-1:0]  remainder;
  logic [ByteW-1:0]  rem_low;
  logic              fix_up;
  logic [QuotW-1:0]  quot;
  logic [CharW-1:0]  digit;

  always_comb begin
    is_full    = (byte_count == LAST_ITER);
    full_word  = {group_word, data_byte};
    word_next  = {group_word[HeldW-ByteW-1:0], data_byte};
    count_next = byte_count + 2'd1;
    case (count_next)
      2'd1:    padded = {word_next[ByteW-1:0], 24'd0};
      2'd2:    padded = {word_next[2*ByteW-1:0], 16'd0};
      2'd3:    padded = {word_next, 8'd0};
      default: padded = {word_next, 8'd0};
    endcase
    is_zero  = (full_word == '0);
    is_space = (full_word == SPACE_WORD);

    product   = 64'(value) * 64'(RECIP);
    base_mult = 32'(quot_est) * 32'(BASE);
    remainder = value - base_mult;
    rem_low   = remainder[ByteW-1:0];
    fix_up    = (rem_low >= BASE);
    quot      = quot_est + QuotW'(fix_up);
    digit     = fix_up ? 7'(rem_low - BASE) : rem_low[CharW-1:0];

    status.shortcut  = is_full && (is_zero || is_space);
    status.start_div = is_full ? !(is_zero || is_space) : last_byte;
    status.fix_done  = (iter == LAST_ITER);
    status.idx_zero  = (idx == '0);
    status.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_word <= '0;
      byte_count <= '0;
    end else if (cmd.in_fire) begin
      if (is_full || last_byte) begin
        group_word <= '0;
        byte_count <= '0;
      end else begin
        group_word <= word_next;
        byte_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_fire) begin
      value <= is_full ? full_word : padded;
      iter  <= '0;
      mlast <= last_byte;
      if (status.shortcut) begin
        digits[0] <= is_zero ? CHAR_Z : CHAR_Y;
        idx       <= '0;
      end else begin
        idx <= TOP_IDX;
      end
    end
    if (cmd.mul_en) begin
      quot_est <= product[2*WordW-1:RecipShift];
    end
    if (cmd.fix_en) begin
      digits[IdxW'(iter)] <= digit + DIGIT_OFFSET;
      value               <= WordW'(quot);
      iter                <= iter + 2'd1;
      if (status.fix_done) begin
        digits[TOP_IDX] <= quot[CharW-1:0] + DIGIT_OFFSET;
      end
    end
    if (cmd.out_load) begin
      out_char     <= digits[idx];
      group_last   <= status.idx_zero;
      message_last <= status.idx_zero && mlast;
      idx          <= idx - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
